// File: rtl/csp_pkg.sv
`default_nettype none
package csp_pkg;

	localparam int MAX_ELEMENTS = 4096;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int COORD_BITS   = 32;
	localparam int MAX_SLICES   = 16;
	localparam int SLICE_W      = 5;
	localparam int NUM_W        = CNT_W + $clog2(MAX_SLICES);
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 32;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [2:0] REG_DIMENSIONS = 3'd0;
	localparam logic [2:0] REG_SLICES_X   = 3'd1;
	localparam logic [2:0] REG_SLICES_Y   = 3'd2;
	localparam logic [2:0] REG_SLICES_Z   = 3'd3;
	localparam logic [2:0] REG_PERIODIC   = 3'd4;

	localparam logic [1:0] DIMS_TWO = 2'd2;

	typedef struct packed {
		logic [1:0]         dimensions;
		logic [SLICE_W-1:0] slices_x;
		logic [SLICE_W-1:0] slices_y;
		logic [SLICE_W-1:0] slices_z;
		logic [2:0]         periodic_mask;
	} cfg_t;

	function automatic logic [SLICE_W-1:0] clamp_slices(input logic [SLICE_W-1:0] s);
		logic [SLICE_W-1:0] r;
		r = s;
		if (s == '0)
			r = SLICE_W'(1);
		else if (s > SLICE_W'(MAX_SLICES))
			r = SLICE_W'(MAX_SLICES);
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/csp_cmd_if.sv
`default_nettype none
interface csp_cmd_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic        last_element;
	logic [11:0] element_index;

	modport source (output valid, action, coord_x, coord_y, coord_z, last_element,
		element_index, input ready);
	modport sink (input valid, action, coord_x, coord_y, coord_z, last_element,
		element_index, output ready);
endinterface
`default_nettype wire

// File: rtl/csp_res_if.sv
`default_nettype none
interface csp_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] part_number;
	logic [11:0] read_index;
	logic        status;

	modport source (output valid, part_number, read_index, status, input ready);
	modport sink (input valid, part_number, read_index, status, output ready);
endinterface
`default_nettype wire

// File: rtl/csp_ram.sv
`default_nettype none
module csp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/csp_div.sv
`default_nettype none
module csp_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [csp_pkg::NUM_W-1:0] num,
	input  wire logic [csp_pkg::CNT_W-1:0] den,
	output logic                           done,
	output logic      [csp_pkg::NUM_W-1:0] quot
);
	import csp_pkg::*;

	logic [CNT_W-1:0]         rem_q;
	logic [NUM_W-1:0]         quo_q;
	logic [$clog2(NUM_W+1)-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W:0]           trial;
	logic                     fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(NUM_W+1))'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(NUM_W+1))'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

// File: rtl/csp_cfg.sv
`default_nettype none
module csp_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [csp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [csp_pkg::PDATA_W-1:0] pwdata,
	output logic      [csp_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output csp_pkg::cfg_t                    cfg
);
	import csp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dimensions    <= 2'd3;
			cfg_q.slices_x      <= SLICE_W'(1);
			cfg_q.slices_y      <= SLICE_W'(1);
			cfg_q.slices_z      <= SLICE_W'(1);
			cfg_q.periodic_mask <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_DIMENSIONS: cfg_q.dimensions    <= pwdata[1:0];
				REG_SLICES_X:   cfg_q.slices_x      <= pwdata[SLICE_W-1:0];
				REG_SLICES_Y:   cfg_q.slices_y      <= pwdata[SLICE_W-1:0];
				REG_SLICES_Z:   cfg_q.slices_z      <= pwdata[SLICE_W-1:0];
				REG_PERIODIC:   cfg_q.periodic_mask <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_DIMENSIONS: prdata = PDATA_W'(cfg_q.dimensions);
			REG_SLICES_X:   prdata = PDATA_W'(cfg_q.slices_x);
			REG_SLICES_Y:   prdata = PDATA_W'(cfg_q.slices_y);
			REG_SLICES_Z:   prdata = PDATA_W'(cfg_q.slices_z);
			REG_PERIODIC:   prdata = PDATA_W'(cfg_q.periodic_mask);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// File: rtl/coordinate_slice_partitioner_top.sv
`default_nettype none
// Loads are written as they are taken; a read presents its address when taken, then
// registers the memory data into the result. The load item that carries last_element
// starts partitioning, during which no item is taken. For each axis, every element e
// is ranked inside its current part by a scan of all n loaded elements through the
// coordinate and part memories (one element per cycle), followed by two serial
// divisions. There is no clearing pass after reset.
module coordinate_slice_partitioner_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	csp_cmd_if.sink                          cmd,
	csp_res_if.source                        res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [csp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [csp_pkg::PDATA_W-1:0] pwdata,
	output logic      [csp_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import csp_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_READ   = 8'b0000_0010,
		S_EFETCH = 8'b0000_0100,
		S_ECAPT  = 8'b0000_1000,
		S_SCAN   = 8'b0001_0000,
		S_DIV1   = 8'b0010_0000,
		S_DIV2   = 8'b0100_0000,
		S_UNUSED = 8'b1000_0000
	} state_t;

	cfg_t   cfg;
	state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic             computed_q;
	logic             bank_q;
	logic [IDX_W-1:0] e_q;
	logic [1:0]       axis_q;
	logic [CNT_W-1:0] f_q;
	logic             scan_v_s1;
	logic [IDX_W-1:0] scan_f_s1;
	logic [CNT_W-1:0] rank_q;
	logic [CNT_W-1:0] size_q;
	logic [CNT_W-1:0] pos_q;
	logic [COORD_BITS-1:0] ex_q, ey_q, ez_q;
	logic [IDX_W-1:0] epart_q;
	logic             div_start_q;
	logic             res_v_q;
	logic [IDX_W-1:0] res_part_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_bad_q;

	csp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	// memories
	logic [IDX_W-1:0]      raddr;
	logic                  coord_we;
	logic [IDX_W-1:0]      coord_waddr;
	logic [COORD_BITS-1:0] fx, fy, fz;
	logic [IDX_W-1:0]      part0_rd, part1_rd, cur_part;
	logic                  part_we;
	logic [IDX_W-1:0]      part_wdata;

	localparam logic [COORD_BITS-1:0] SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};

	csp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ELEMENTS)) u_xmem (
		.clk, .we(coord_we), .waddr(coord_waddr), .wdata(cmd.coord_x ^ SIGN),
		.raddr, .rdata(fx)
	);
	csp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ELEMENTS)) u_ymem (
		.clk, .we(coord_we), .waddr(coord_waddr), .wdata(cmd.coord_y ^ SIGN),
		.raddr, .rdata(fy)
	);
	csp_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ELEMENTS)) u_zmem (
		.clk, .we(coord_we), .waddr(coord_waddr), .wdata(cmd.coord_z ^ SIGN),
		.raddr, .rdata(fz)
	);
	csp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_part0 (
		.clk, .we(part_we && bank_q), .waddr(e_q), .wdata(part_wdata),
		.raddr, .rdata(part0_rd)
	);
	csp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_part1 (
		.clk, .we(part_we && !bank_q), .waddr(e_q), .wdata(part_wdata),
		.raddr, .rdata(part1_rd)
	);
	assign cur_part = bank_q ? part1_rd : part0_rd;

	// axis settings
	logic               three;
	logic [1:0]         last_axis;
	logic [SLICE_W-1:0] s_cur;
	logic               periodic;

	assign three     = cfg.dimensions != DIMS_TWO;
	assign last_axis = three ? 2'd2 : 2'd1;
	assign s_cur     = clamp_slices(axis_q == 2'd0 ? cfg.slices_x :
		(axis_q == 2'd1 ? cfg.slices_y : cfg.slices_z));
	assign periodic  = cfg.periodic_mask[axis_q];

	// handshakes
	logic acc, acc_load, acc_read, store_ok;
	logic [CNT_W-1:0] cnt_eff;

	assign cmd.ready = (state_q == S_IDLE) && (!res_v_q || res.ready);
	assign acc       = cmd.valid && cmd.ready;
	assign acc_load  = acc && (cmd.action == ACT_LOAD);
	assign acc_read  = acc && (cmd.action == ACT_READ);
	assign cnt_eff   = computed_q ? '0 : cnt_q;
	assign store_ok  = cnt_eff < CNT_W'(MAX_ELEMENTS);
	assign coord_we  = acc_load && store_ok;
	assign coord_waddr = cnt_eff[IDX_W-1:0];

	always_comb begin
		case (state_q)
			S_IDLE:  raddr = cmd.element_index;
			S_SCAN:  raddr = f_q[IDX_W-1:0];
			default: raddr = e_q;
		endcase
	end

	// key compare: element f before element e
	logic [COORD_BITS-1:0] pf, pe, sf, se, tf, te;
	logic                  f_less, same_part;

	always_comb begin
		case (axis_q)
			2'd0: begin
				pf = fx; pe = ex_q; sf = fy; se = ey_q; tf = fz; te = ez_q;
			end
			2'd1: begin
				pf = fy; pe = ey_q; sf = fx; se = ex_q; tf = fz; te = ez_q;
			end
			default: begin
				pf = fz; pe = ez_q; sf = fx; se = ex_q; tf = fy; te = ey_q;
			end
		endcase
		f_less = (pf < pe) || ((pf == pe) && ((sf < se) || ((sf == se) &&
			((three && (tf < te)) || ((!three || (tf == te)) && (scan_f_s1 < e_q))))));
		same_part = (axis_q == 2'd0) || (cur_part == epart_q);
	end

	// shared divider: rotation amount, then slice index
	logic [NUM_W-1:0] div_num, div_quot;
	logic [CNT_W-1:0] div_den;
	logic             div_done;
	logic [CNT_W-1:0] pos_sum, pos_wrap;
	logic [NUM_W-1:0] slice_num;

	assign slice_num = (NUM_W'(pos_q) + NUM_W'(1)) * NUM_W'(s_cur) - NUM_W'(1);

	always_comb begin
		if (state_q == S_DIV1) begin
			div_num = NUM_W'(size_q);
			div_den = CNT_W'({s_cur, 1'b0});
		end else begin
			div_num = slice_num;
			div_den = size_q;
		end
	end

	csp_div u_div (
		.clk, .arst_n, .start(div_start_q), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	assign pos_sum  = rank_q + (periodic ? div_quot[CNT_W-1:0] : '0);
	assign pos_wrap = (pos_sum >= size_q) ? pos_sum - size_q : pos_sum;

	assign part_we    = (state_q == S_DIV2) && div_done;
	assign part_wdata = IDX_W'(epart_q * s_cur) + IDX_W'(div_quot[SLICE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			computed_q  <= 1'b0;
			bank_q      <= 1'b0;
			e_q         <= '0;
			axis_q      <= '0;
			f_q         <= '0;
			scan_v_s1   <= 1'b0;
			div_start_q <= 1'b0;
			res_v_q     <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (res_v_q && res.ready)
				res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_load) begin
						computed_q <= 1'b0;
						cnt_q      <= store_ok ? cnt_eff + 1'b1 : cnt_eff;
						if (cmd.last_element) begin
							state_q <= S_EFETCH;
							e_q     <= '0;
							axis_q  <= '0;
						end
					end else if (acc_read) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_EFETCH: state_q <= S_ECAPT;
				S_ECAPT: begin
					f_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (f_q < cnt_q) begin
						scan_v_s1 <= 1'b1;
						f_q       <= f_q + 1'b1;
					end else begin
						scan_v_s1 <= 1'b0;
						if (!scan_v_s1) begin
							state_q     <= S_DIV1;
							div_start_q <= 1'b1;
						end
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q     <= S_DIV2;
						div_start_q <= 1'b1;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_EFETCH;
						if (CNT_W'(e_q) == cnt_q - 1'b1) begin
							e_q    <= '0;
							bank_q <= !bank_q;
							axis_q <= axis_q + 1'b1;
							if (axis_q == last_axis) begin
								computed_q <= 1'b1;
								state_q    <= S_IDLE;
							end
						end else begin
							e_q <= e_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ECAPT) begin
			ex_q    <= fx;
			ey_q    <= fy;
			ez_q    <= fz;
			epart_q <= (axis_q == 2'd0) ? '0 : cur_part;
			rank_q  <= '0;
			size_q  <= '0;
		end
		if (state_q == S_SCAN) begin
			scan_f_s1 <= f_q[IDX_W-1:0];
			if (scan_v_s1 && same_part) begin
				size_q <= size_q + 1'b1;
				if (f_less)
					rank_q <= rank_q + 1'b1;
			end
		end
		if (state_q == S_DIV1 && div_done)
			pos_q <= pos_wrap;
		if (acc_read) begin
			rd_idx_q <= cmd.element_index;
			rd_bad_q <= !computed_q || (CNT_W'(cmd.element_index) >= cnt_q);
		end
		if (state_q == S_READ)
			res_part_q <= rd_bad_q ? '0 : cur_part;
	end

	assign res.valid       = res_v_q;
	assign res.part_number = res_part_q;
	assign res.read_index  = rd_idx_q;
	assign res.status      = rd_bad_q;
endmodule
`default_nettype wire

// File: rtl/csp_checker.sv
`default_nettype none
module csp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        cmd_action,
	input wire logic [11:0] cmd_element_index,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [11:0] res_part_number,
	input wire logic [11:0] res_read_index,
	input wire logic        res_status
);
	import csp_pkg::*;

	// failed reads report part zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status |-> res_part_number == '0)
		else $error("status set with nonzero part");

	// a read item is answered after the read state registers its result
	a_read_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_READ |=> ##1 res_valid)
		else $error("read item not answered");

	a_read_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_READ
		|=> res_read_index == $past(cmd_element_index))
		else $error("read index mismatch");

	// no new item while a stalled result is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !cmd_ready)
		else $error("item taken while result stalled");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_part_number))
		else $error("stalled result dropped");
endmodule

bind coordinate_slice_partitioner_top csp_checker u_csp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_action(cmd.action),
	.cmd_element_index(cmd.element_index),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_part_number(res.part_number),
	.res_read_index(res.read_index),
	.res_status(res.status)
);
`default_nettype wire
